>>> hdl/mcbd_pkg.sv
`timescale 1ns / 1ps

package mcbd_pkg;

  // Configuration registers are 16 bits wide; timers default to the same width.
  localparam int CFG_W              = 16;
  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_W        = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_ON  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_OFF = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd20;
  localparam logic [CFG_W-1:0] GAP_RESET       = 16'd500;
  localparam logic [CFG_W-1:0] BLINK_ON_RESET  = 16'd400;
  localparam logic [CFG_W-1:0] BLINK_OFF_RESET = 16'd200;

  localparam int CLICK_W = 8;
  localparam int BLINK_N_W = 3;

  // Stream data widths (fields padded to whole bytes).
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;

  typedef enum logic [2:0] {
    ACT_NONE            = 3'd0,
    ACT_SET_MARKER      = 3'd1,
    ACT_TOGGLE_SAMPLING = 3'd2,
    ACT_DISABLE_SHELL   = 3'd3,
    ACT_SOFT_RESET      = 3'd4
  } action_t;

  // Request from the click decoder to start a confirm blink run.
  typedef struct packed {
    logic                 start;
    logic [BLINK_N_W-1:0] count;
  } blink_start_t;

  typedef struct packed {
    logic    green_led;
    action_t action;
  } result_t;

endpackage

>>> hdl/mcbd_click.sv
`timescale 1ns / 1ps

module mcbd_click #(
  parameter int TIMER_BITS = mcbd_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  button_level,
  input  logic                  press_edge,
  input  logic [TIMER_BITS-1:0] debounce_len,
  input  logic [TIMER_BITS-1:0] gap_len,
  output mcbd_pkg::action_t     action,
  output mcbd_pkg::blink_start_t blink_start
);

  logic                         press_in_progress, press_in_progress_next;
  logic [mcbd_pkg::CLICK_W-1:0] click_count, click_count_next;
  logic [TIMER_BITS-1:0]        debounce_left, debounce_left_next;
  logic                         debounce_running, debounce_running_next;
  logic [TIMER_BITS-1:0]        gap_left, gap_left_next;
  logic                         gap_running, gap_running_next;

  logic                  deb_fresh, gap_fresh;
  logic [TIMER_BITS-1:0] deb_dec, gap_dec;
  logic                  deb_expired, gap_expired;

  always_comb begin
    press_in_progress_next = press_in_progress;
    click_count_next       = click_count;
    debounce_left_next     = debounce_left;
    debounce_running_next  = debounce_running;
    gap_left_next          = gap_left;
    gap_running_next       = gap_running;
    deb_fresh              = 1'b0;
    gap_fresh              = 1'b0;
    deb_dec                = '0;
    gap_dec                = '0;
    deb_expired            = 1'b0;
    gap_expired            = 1'b0;
    action                 = mcbd_pkg::ACT_NONE;
    blink_start            = '0;

    // A press edge is a click only outside a press.
    if (press_edge && !press_in_progress) begin
      press_in_progress_next = 1'b1;
      click_count_next       = click_count + mcbd_pkg::CLICK_W'(1);
      debounce_left_next     = debounce_len;
      debounce_running_next  = 1'b1;
      deb_fresh              = 1'b1;
      gap_left_next          = gap_len;
      gap_running_next       = 1'b1;
      gap_fresh              = 1'b1;
    end

    // Debounce one-shot: re-arm while held, else end the press and restart the gap.
    if (debounce_running_next && !deb_fresh) begin
      deb_dec = (debounce_left_next != '0) ? debounce_left_next - TIMER_BITS'(1) : '0;
      debounce_left_next = deb_dec;
      if (deb_dec == '0) begin
        debounce_running_next = 1'b0;
        deb_expired           = 1'b1;
      end
    end
    if (deb_expired) begin
      if (button_level) begin
        debounce_left_next    = debounce_len;
        debounce_running_next = 1'b1;
      end else begin
        gap_left_next          = gap_len;
        gap_running_next       = 1'b1;
        gap_fresh              = 1'b1;
        press_in_progress_next = 1'b0;
      end
    end

    // Gap one-shot: decode the click count.
    if (gap_running_next && !gap_fresh) begin
      gap_dec = (gap_left_next != '0) ? gap_left_next - TIMER_BITS'(1) : '0;
      gap_left_next = gap_dec;
      if (gap_dec == '0) begin
        gap_running_next = 1'b0;
        gap_expired      = 1'b1;
      end
    end
    if (gap_expired) begin
      unique case (click_count_next)
        8'd1: begin
          action            = mcbd_pkg::ACT_SET_MARKER;
          blink_start.start = 1'b1;
          blink_start.count = 3'd1;
        end
        8'd2: begin
          action            = mcbd_pkg::ACT_TOGGLE_SAMPLING;
          blink_start.start = 1'b1;
          blink_start.count = 3'd2;
        end
        8'd4: begin
          action            = mcbd_pkg::ACT_DISABLE_SHELL;
          blink_start.start = 1'b1;
          blink_start.count = 3'd4;
        end
        8'd5: begin
          action            = mcbd_pkg::ACT_SOFT_RESET;
          blink_start.start = 1'b1;
          blink_start.count = 3'd5;
        end
        default: begin
          action = mcbd_pkg::ACT_NONE;
        end
      endcase
      click_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_in_progress <= 1'b0;
      click_count       <= '0;
      debounce_left     <= '0;
      debounce_running  <= 1'b0;
      gap_left          <= '0;
      gap_running       <= 1'b0;
    end else if (advance) begin
      press_in_progress <= press_in_progress_next;
      click_count       <= click_count_next;
      debounce_left     <= debounce_left_next;
      debounce_running  <= debounce_running_next;
      gap_left          <= gap_left_next;
      gap_running       <= gap_running_next;
    end
  end

`ifndef SYNTHESIS
  // The debounce one-shot runs exactly for the length of a press.
  assert property (@(posedge clk) disable iff (rst) press_in_progress == debounce_running)
    else $error("debounce timer out of step with press state");

  // A running gap timer never sits at zero.
  assert property (@(posedge clk) disable iff (rst) gap_running |-> (gap_left != '0))
    else $error("gap timer running with zero count");
`endif

endmodule

>>> hdl/mcbd_blink.sv
`timescale 1ns / 1ps

module mcbd_blink #(
  parameter int TIMER_BITS = mcbd_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  mcbd_pkg::blink_start_t blink_start,
  input  logic [TIMER_BITS-1:0]  on_len,
  input  logic [TIMER_BITS-1:0]  off_len,
  output logic                   green_led
);

  logic [TIMER_BITS-1:0]          blink_left, blink_left_next;
  logic                           blink_running, blink_running_next;
  logic [mcbd_pkg::BLINK_N_W-1:0] blinks_remaining, blinks_remaining_next;
  logic                           led_state, led_state_next;

  logic                  blink_fresh, blink_expired;
  logic [TIMER_BITS-1:0] blink_dec, next_len;

  always_comb begin
    blink_left_next       = blink_left;
    blink_running_next    = blink_running;
    blinks_remaining_next = blinks_remaining;
    led_state_next        = led_state;
    blink_fresh           = 1'b0;
    blink_expired         = 1'b0;
    blink_dec             = '0;
    next_len              = on_len;

    if (blink_start.start) begin
      led_state_next        = 1'b1;
      blinks_remaining_next = blink_start.count;
      blink_left_next       = on_len;
      blink_running_next    = 1'b1;
      blink_fresh           = 1'b1;
    end

    if (blink_running_next && !blink_fresh) begin
      blink_dec = (blink_left_next != '0) ? blink_left_next - TIMER_BITS'(1) : '0;
      blink_left_next = blink_dec;
      if (blink_dec == '0) begin
        blink_running_next = 1'b0;
        blink_expired      = 1'b1;
      end
    end

    // Swap phase; stop after the last on phase.
    if (blink_expired) begin
      if (led_state_next) begin
        blinks_remaining_next = blinks_remaining_next - mcbd_pkg::BLINK_N_W'(1);
        led_state_next        = 1'b0;
        next_len              = off_len;
      end else begin
        led_state_next = 1'b1;
        next_len       = on_len;
      end
      if (blinks_remaining_next != '0) begin
        blink_left_next    = next_len;
        blink_running_next = 1'b1;
      end
    end

    green_led = led_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_left       <= '0;
      blink_running    <= 1'b0;
      blinks_remaining <= '0;
      led_state        <= 1'b0;
    end else if (advance) begin
      blink_left       <= blink_left_next;
      blink_running    <= blink_running_next;
      blinks_remaining <= blinks_remaining_next;
      led_state        <= led_state_next;
    end
  end

`ifndef SYNTHESIS
  // The LED is only lit inside a blink run.
  assert property (@(posedge clk) disable iff (rst) led_state |-> blink_running)
    else $error("LED on with no blink run");

  // A running blink run always has blinks left.
  assert property (@(posedge clk) disable iff (rst)
      blink_running |-> (blinks_remaining != '0))
    else $error("blink run with no blinks remaining");
`endif

endmodule

>>> hdl/mcbd_obuf.sv
`timescale 1ns / 1ps

module mcbd_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mcbd_pkg::result_t result,
  output logic              ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output mcbd_pkg::result_t m_result
);

  // Take a new result when the buffer is empty or the held one is being drained.
  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= result;
    end
  end

endmodule

>>> hdl/multi_click_button_decoder_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat content (lowest bit first)
// s_axis    in   tdata: button_level[0], press_edge[1], zero pad[7:2]
// m_axis    out  tdata: action[2:0], green_led[3], zero pad[7:4]
// cfg       in   cfg_we / cfg_index / cfg_data, index 0 debounce, 1 gap, 2 blink on, 3 off
//
// One input beat is one tick and gives exactly one output beat.
// Each tick is decoded combinationally and written at the accept edge into the output
// register, so a beat can be taken every cycle unless the output stalls; the output register sets the rate.
// Reset (rst, synchronous) clears all timers and counts and restores the
// register defaults 20 / 500 / 400 / 200 ticks.
// A stalled output holds its beat; s_tready drops only while it is full and m_tready is low.

module multi_click_button_decoder_core #(
  parameter int TIMER_BITS = mcbd_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [mcbd_pkg::S_TDATA_W-1:0]        s_tdata,   // button_level, press_edge, pad
  // Output stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mcbd_pkg::M_TDATA_W-1:0]        m_tdata,   // action[2:0], green_led, pad
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [mcbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mcbd_pkg::CFG_W-1:0]            cfg_data
);

  localparam int EXT_W = (TIMER_BITS > mcbd_pkg::CFG_W) ? TIMER_BITS : mcbd_pkg::CFG_W;
  localparam logic [EXT_W-1:0] TIMER_MAX = EXT_W'((64'd1 << TIMER_BITS) - 64'd1);

  // Turn a register value into a one-shot length: zero acts as one,
  // anything above the timer range saturates.
  function automatic logic [TIMER_BITS-1:0] load_len(input logic [mcbd_pkg::CFG_W-1:0] cfg);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(cfg);
    if (ext == '0) begin
      ext = EXT_W'(1);
    end
    if (ext > TIMER_MAX) begin
      ext = TIMER_MAX;
    end
    return TIMER_BITS'(ext);
  endfunction

  // Lengths are held already converted, so the tick path sees plain loads.
  logic [TIMER_BITS-1:0] debounce_len, gap_len, on_len, off_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_len <= load_len(mcbd_pkg::DEBOUNCE_RESET);
      gap_len      <= load_len(mcbd_pkg::GAP_RESET);
      on_len       <= load_len(mcbd_pkg::BLINK_ON_RESET);
      off_len      <= load_len(mcbd_pkg::BLINK_OFF_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcbd_pkg::REG_DEBOUNCE:  debounce_len <= load_len(cfg_data);
        mcbd_pkg::REG_GAP:       gap_len      <= load_len(cfg_data);
        mcbd_pkg::REG_BLINK_ON:  on_len       <= load_len(cfg_data);
        mcbd_pkg::REG_BLINK_OFF: off_len      <= load_len(cfg_data);
        default: ;
      endcase
    end
  end

  logic                   advance;
  mcbd_pkg::action_t      action;
  mcbd_pkg::blink_start_t blink_start;
  logic                   green_led;
  mcbd_pkg::result_t      result, m_result;

  // Advance the decoder state on every accepted beat.
  assign advance = s_tvalid && s_tready;

  mcbd_click #(
    .TIMER_BITS (TIMER_BITS)
  ) u_click (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .button_level (s_tdata[0]),
    .press_edge   (s_tdata[1]),
    .debounce_len (debounce_len),
    .gap_len      (gap_len),
    .action       (action),
    .blink_start  (blink_start)
  );

  mcbd_blink #(
    .TIMER_BITS (TIMER_BITS)
  ) u_blink (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .blink_start (blink_start),
    .on_len      (on_len),
    .off_len     (off_len),
    .green_led   (green_led)
  );

  always_comb begin
    result.action    = action;
    result.green_led = green_led;
  end

  mcbd_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result)
  );

  assign m_tdata = mcbd_pkg::M_TDATA_W'({m_result.green_led, m_result.action});

endmodule

>>> bench/multi_click_button_decoder_core_tb.sv
`timescale 1ns / 1ps

class click_tracker;
  localparam int TMR_DEBOUNCE = 0;
  localparam int TMR_GAP      = 1;
  localparam int TMR_BLINK    = 2;

  // Register copies as written
  logic [15:0] deb_len, gap_len, on_len, off_len;

  // Decoder state
  bit          pressing;
  bit [7:0]    clicks;
  bit [15:0]   left [3];
  bit          running [3];
  bit [2:0]    blinks_left;
  bit          led;

  mcbd_pkg::result_t outcomes [$];
  int unsigned       ticks;
  int unsigned       mismatches;

  function new();
    deb_len     = mcbd_pkg::DEBOUNCE_RESET;
    gap_len     = mcbd_pkg::GAP_RESET;
    on_len      = mcbd_pkg::BLINK_ON_RESET;
    off_len     = mcbd_pkg::BLINK_OFF_RESET;
    pressing    = 1'b0;
    clicks      = '0;
    blinks_left = '0;
    led         = 1'b0;
    ticks       = 0;
    mismatches  = 0;
    for (int k = 0; k < 3; k++) begin
      left[k]    = '0;
      running[k] = 1'b0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      mcbd_pkg::REG_DEBOUNCE:  deb_len = val;
      mcbd_pkg::REG_GAP:       gap_len = val;
      mcbd_pkg::REG_BLINK_ON:  on_len  = val;
      mcbd_pkg::REG_BLINK_OFF: off_len = val;
      default: ;
    endcase
  endfunction

  // A zero length behaves as one tick
  function void arm(int k, logic [15:0] len);
    left[k]    = (len == 0) ? 16'd1 : len;
    running[k] = 1'b1;
  endfunction

  // Count a running timer down unless loaded this tick; true on expiry
  function bit expire(int k, bit fresh);
    if (!running[k] || fresh) return 1'b0;
    if (left[k] != 0) left[k] = left[k] - 16'd1;
    if (left[k] == 0) begin
      running[k] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void log_tick(bit lvl, bit edg);
    bit [2:0]          fresh;
    bit [2:0]          run_len;
    logic [15:0]       nxt;
    mcbd_pkg::action_t act;
    mcbd_pkg::result_t r;
    fresh = '0;
    act   = mcbd_pkg::ACT_NONE;
    ticks++;

    if (edg && !pressing) begin
      pressing = 1'b1;
      clicks   = clicks + 8'd1;
      arm(TMR_DEBOUNCE, deb_len);
      arm(TMR_GAP, gap_len);
      fresh[TMR_DEBOUNCE] = 1'b1;
      fresh[TMR_GAP]      = 1'b1;
    end

    if (expire(TMR_DEBOUNCE, fresh[TMR_DEBOUNCE])) begin
      if (lvl) begin
        arm(TMR_DEBOUNCE, deb_len);
      end else begin
        arm(TMR_GAP, gap_len);
        fresh[TMR_GAP] = 1'b1;
        pressing       = 1'b0;
      end
    end

    if (expire(TMR_GAP, fresh[TMR_GAP])) begin
      run_len = '0;
      case (clicks)
        8'd1: begin act = mcbd_pkg::ACT_SET_MARKER;      run_len = 3'd1; end
        8'd2: begin act = mcbd_pkg::ACT_TOGGLE_SAMPLING; run_len = 3'd2; end
        8'd4: begin act = mcbd_pkg::ACT_DISABLE_SHELL;   run_len = 3'd4; end
        8'd5: begin act = mcbd_pkg::ACT_SOFT_RESET;      run_len = 3'd5; end
        default: ;
      endcase
      clicks = '0;
      if (run_len != 0) begin
        led         = 1'b1;
        blinks_left = run_len;
        arm(TMR_BLINK, on_len);
        fresh[TMR_BLINK] = 1'b1;
      end
    end

    if (expire(TMR_BLINK, fresh[TMR_BLINK])) begin
      if (led) begin
        blinks_left = blinks_left - 3'd1;
        led         = 1'b0;
        nxt         = off_len;
      end else begin
        led = 1'b1;
        nxt = on_len;
      end
      if (blinks_left != 0) arm(TMR_BLINK, nxt);
    end

    r.action    = act;
    r.green_led = led;
    outcomes.push_back(r);
  endfunction

  function void match_outcome(logic [2:0] act, logic grn);
    mcbd_pkg::result_t want;
    if (outcomes.size() == 0) begin
      $display("%0t: unexpected beat, action %0d green %0d", $time, act, grn);
      mismatches++;
      return;
    end
    want = outcomes.pop_front();
    if (act !== want.action) begin
      $display("%0t: action expected %0d, got %0d", $time, want.action, act);
      mismatches++;
    end
    if (grn !== want.green_led) begin
      $display("%0t: green_led expected %0d, got %0d", $time, want.green_led, grn);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return outcomes.size();
  endfunction
endclass

module multi_click_button_decoder_core_tb;

  // Cycles without any beat on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [mcbd_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [mcbd_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                             cfg_we    = 1'b0;
  logic [mcbd_pkg::CFG_INDEX_W-1:0] cfg_index = mcbd_pkg::REG_DEBOUNCE;
  logic [mcbd_pkg::CFG_W-1:0]       cfg_data  = '0;

  click_tracker board = new();

  // Idle and stall odds in percent, changed per phase
  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet_cycles = 0;

  // Effective timer lengths, used only to shape click sequences
  int unsigned cur_deb = 20, cur_gap = 500, cur_on = 400, cur_off = 200;

  // Opening ticks, {press_edge, button_level}: idle, level alone, a click
  // with the button already up, its action and single blink, a held press
  // that re-arms the debounce while a bounce edge is ignored, then four
  // quick clicks
  bit [1:0] opening [19] = '{2'b00, 2'b01, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00,
                             2'b11, 2'b11, 2'b01, 2'b00, 2'b10, 2'b00, 2'b10,
                             2'b00, 2'b10, 2'b00, 2'b10, 2'b00};

  multi_click_button_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // button_level[0], press_edge[1], zero pad
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // action[2:0], green_led[3], zero pad
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Check every result beat, and abandon the run if beats stop moving
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.match_outcome(m_tdata[2:0], m_tdata[3]);
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one tick, idling first at random; return at the accepting edge
  task automatic send_tick(input bit lvl, input bit edg);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, edg, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.log_tick(lvl, edg);
  endtask

  // Leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [mcbd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mcbd_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Drain all outstanding results, then rewrite every register
  task automatic configure(input logic [mcbd_pkg::CFG_W-1:0] d, g, on, off);
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(mcbd_pkg::REG_DEBOUNCE, d);
    write_reg(mcbd_pkg::REG_GAP, g);
    write_reg(mcbd_pkg::REG_BLINK_ON, on);
    write_reg(mcbd_pkg::REG_BLINK_OFF, off);
    cfg_we  <= 1'b0;
    cur_deb = (d == 0) ? 1 : d;
    cur_gap = (g == 0) ? 1 : g;
    cur_on  = (on == 0) ? 1 : on;
    cur_off = (off == 0) ? 1 : off;
  endtask

  // One multi-click sequence: press, hold with the odd bounce edge, release
  // mostly inside the gap so the count carries on, then go quiet long
  // enough for the action and its blink run
  task automatic click_burst(input int unsigned n);
    int unsigned hold;
    int unsigned quiet;
    for (int unsigned c = 0; c < n; c++) begin
      send_tick(1'b1, 1'b1);
      hold = $urandom_range(2 * cur_deb, 0);
      repeat (hold) send_tick(1'b1, $urandom_range(7) == 0);
      repeat ($urandom_range(cur_deb + cur_gap - 1, cur_deb)) send_tick(1'b0, 1'b0);
    end
    quiet = $urandom_range(cur_gap + n * (cur_on + cur_off) + 4, cur_gap);
    repeat (quiet) send_tick(1'b0, 1'b0);
  endtask

  task automatic random_phase(input int unsigned idle_pct, stall_pct, n_ticks);
    int unsigned stop_at;
    int unsigned bursts;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    stop_at    = board.ticks + n_ticks;
    bursts     = 0;
    while (board.ticks < stop_at) begin
      if (bursts % 3 == 0) begin
        configure($urandom_range(4, 0), $urandom_range(8, 0),
                  $urandom_range(4, 0), $urandom_range(4, 0));
      end
      if ($urandom_range(9) == 0) begin
        // Noise: random level and edges that break up any sequence
        repeat ($urandom_range(6, 1)) send_tick($urandom_range(1), $urandom_range(3) == 0);
      end else begin
        click_burst($urandom_range(7, 1));
      end
      bursts++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening ticks: zero debounce length acts as one tick
    configure(16'd0, 16'd2, 16'd1, 16'd0);
    foreach (opening[i]) send_tick(opening[i][0], opening[i][1]);
    repeat (12) send_tick(1'b0, 1'b0);

    random_phase(0, 0, 300);
    random_phase(63, 0, 300);
    random_phase(0, 63, 300);
    random_phase(12, 12, 300);

    // Click count wraps: 257 clicks decode as one
    configure(16'd1, 16'd2, 16'd1, 16'd1);
    repeat (257) begin
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
    end
    repeat (6) send_tick(1'b0, 1'b0);

    // Longest lengths last: the debounce never expires again after this
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 1'b1);
    repeat (20) send_tick(1'b1, $urandom_range(1));
    repeat (20) send_tick(1'b0, $urandom_range(1));

    // Drain, then leave time for any stray beat
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
